// ===== hw/rtl/nqb_pkg.sv =====
// Shared constants, types and helpers for the N-queens backtracking solver.
// Used by the solver top level, the row picker and the port checker.
`timescale 1ns / 1ps

package nqb_pkg;

    localparam int MAX_QUEENS  = 16;
    localparam int ROW_W       = $clog2(MAX_QUEENS);
    localparam int CNT_W       = ROW_W + 1;
    localparam int DIAG_W      = 2 * MAX_QUEENS - 1;
    localparam int PLACE_W     = MAX_QUEENS * ROW_W;
    localparam int SIZE_W      = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ((1 + PLACE_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(8);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_POP,
        S_PACK,
        S_DONE
    } nqb_state_t;

    // Result of the free-row search in one column
    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
    } nqb_pick_t;

    // Clamp the written board size to 1..MAX_QUEENS
    function automatic logic [CNT_W-1:0] size_in_use(input logic [SIZE_W-1:0] bs);
        logic [CNT_W-1:0] n;
        if (bs == '0)
            n = CNT_W'(1);
        else if (bs > SIZE_W'(MAX_QUEENS))
            n = CNT_W'(MAX_QUEENS);
        else
            n = CNT_W'(bs);
        return n;
    endfunction

endpackage

// ===== hw/rtl/n_queens_backtrack_solver.sv =====
// Top level of the N-queens backtracking solver: search control, queen row memory,
// occupancy masks and output register. Depends on nqb_pkg and nqb_row_pick.
//
//   Channel  Dir  Handshake            Payload
//   s_*      in   s_tvalid / s_tready  s_tdata[0] = restart
//   m_*      out  m_tvalid / m_tready  m_tdata[0] = found, [64:1] = placement
//   cfg_*    in   cfg_valid/cfg_ready  cfg_data = board_size
//
// A restart that finds a placement runs from acceptance to a filled output register
// through P placements, B backtracks (a search step with no free row, then a pop to
// read the popped row from the queen memory), one completion check, a sweep of the
// queen memory to pack the placement, and the load. A continue adds its opening pop;
// a search that runs out skips the sweep, and a continue on an exhausted search
// goes straight to the load.
// Reset leaves the block idle with the search exhausted; no clearing pass runs.
// A full output register stalls the finished request until m_tready frees it.
`timescale 1ns / 1ps

module n_queens_backtrack_solver
    import nqb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] found, [64:1] placement, [71:65] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SIZE_W-1:0]      cfg_data
);

    nqb_state_t state_reg, state_next;

    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [CNT_W-1:0]      depth_reg, depth_next;
    logic [MAX_QUEENS-1:0] row_taken_reg, row_taken_next;
    logic [DIAG_W-1:0]     rise_reg, rise_next;
    logic [DIAG_W-1:0]     fall_reg, fall_next;
    logic                  exhausted_reg, exhausted_next;
    logic [CNT_W-1:0]      try_row_reg, try_row_next;
    logic [CNT_W-1:0]      pack_cnt_reg, pack_cnt_next;
    logic                  pend_reg, pend_next;
    logic [ROW_W-1:0]      pend_col_reg, pend_col_next;
    logic                  found_reg, found_next;
    logic [PLACE_W-1:0]    place_reg, place_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg;
    logic [PLACE_W-1:0]    out_place_reg;

    logic [ROW_W-1:0]      queen_mem [MAX_QUEENS];
    logic [ROW_W-1:0]      rd_data_reg;
    logic                  mem_we;
    logic [ROW_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    logic                  mem_re;
    logic [ROW_W-1:0]      mem_raddr;

    logic [CNT_W-1:0]      size_use;
    logic [ROW_W-1:0]      col;
    logic [ROW_W-1:0]      tog_row;
    logic [CNT_W-1:0]      rise_idx;
    logic [CNT_W-1:0]      fall_idx;
    logic [MAX_QUEENS-1:0] tog_row_mask;
    logic [DIAG_W-1:0]     tog_rise_mask;
    logic [DIAG_W-1:0]     tog_fall_mask;
    logic                  req_fire;
    logic                  cfg_fire;
    logic                  out_load;
    nqb_pick_t             pick;

    assign size_use  = size_in_use(size_reg);
    assign col       = depth_reg[ROW_W-1:0];
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign req_fire  = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // Find the next safe row in the current column
    nqb_row_pick u_pick (
        .row_taken  (row_taken_reg),
        .rise_taken (rise_reg),
        .fall_taken (fall_reg),
        .col        (col),
        .start_row  (try_row_reg),
        .size       (size_use),
        .pick       (pick)
    );

    // Build the occupancy toggle for a placed or popped queen
    assign tog_row       = (state_reg == S_POP) ? rd_data_reg : pick.row;
    assign rise_idx      = {1'b0, tog_row} + {1'b0, col};
    assign fall_idx      = {1'b0, tog_row} + CNT_W'(MAX_QUEENS - 1) - {1'b0, col};
    assign tog_row_mask  = MAX_QUEENS'(1) << tog_row;
    assign tog_rise_mask = DIAG_W'(1) << rise_idx;
    assign tog_fall_mask = DIAG_W'(1) << fall_idx;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (s_tdata[0])
                        state_next = S_SEARCH;
                    else if (exhausted_reg || depth_reg == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_POP;
                end
            end
            S_SEARCH:
            begin
                if (depth_reg >= size_use)
                    state_next = S_PACK;
                else if (pick.hit)
                    state_next = S_SEARCH;
                else if (depth_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_POP;
            end
            S_POP:
                state_next = S_SEARCH;
            S_PACK:
            begin
                if (pack_cnt_reg == size_use && !pend_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        size_next      = size_reg;
        depth_next     = depth_reg;
        row_taken_next = row_taken_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        exhausted_next = exhausted_reg;
        try_row_next   = try_row_reg;
        pack_cnt_next  = pack_cnt_reg;
        pend_next      = 1'b0;
        pend_col_next  = pend_col_reg;
        found_next     = found_reg;
        place_next     = place_reg;
        mem_we         = 1'b0;
        mem_waddr      = col;
        mem_wdata      = pick.row;
        mem_re         = 1'b0;
        mem_raddr      = ROW_W'(depth_reg - CNT_W'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    // Abandon any search on a new board size
                    size_next      = cfg_data;
                    depth_next     = '0;
                    row_taken_next = '0;
                    rise_next      = '0;
                    fall_next      = '0;
                    exhausted_next = 1'b1;
                end
                else if (req_fire)
                begin
                    found_next = 1'b0;
                    place_next = '0;
                    if (s_tdata[0])
                    begin
                        depth_next     = '0;
                        row_taken_next = '0;
                        rise_next      = '0;
                        fall_next      = '0;
                        exhausted_next = 1'b0;
                        try_row_next   = '0;
                    end
                    else if (!exhausted_reg && depth_reg == '0)
                    begin
                        exhausted_next = 1'b1;
                    end
                    else if (!exhausted_reg)
                    begin
                        // Pop the last queen to resume past the previous placement
                        mem_re     = 1'b1;
                        depth_next = depth_reg - CNT_W'(1);
                    end
                end
            end
            S_SEARCH:
            begin
                if (depth_reg >= size_use)
                begin
                    found_next    = 1'b1;
                    pack_cnt_next = '0;
                end
                else if (pick.hit)
                begin
                    // Place the queen and advance one column
                    mem_we         = 1'b1;
                    row_taken_next = row_taken_reg ^ tog_row_mask;
                    rise_next      = rise_reg ^ tog_rise_mask;
                    fall_next      = fall_reg ^ tog_fall_mask;
                    depth_next     = depth_reg + CNT_W'(1);
                    try_row_next   = '0;
                end
                else if (depth_reg == '0)
                begin
                    exhausted_next = 1'b1;
                end
                else
                begin
                    // Backtrack: fetch the previous column's row
                    mem_re     = 1'b1;
                    depth_next = depth_reg - CNT_W'(1);
                end
            end
            S_POP:
            begin
                // Remove the fetched queen and retry its column one row higher
                row_taken_next = row_taken_reg ^ tog_row_mask;
                rise_next      = rise_reg ^ tog_rise_mask;
                fall_next      = fall_reg ^ tog_fall_mask;
                try_row_next   = {1'b0, rd_data_reg} + CNT_W'(1);
            end
            S_PACK:
            begin
                // Sweep the queen memory into the packed placement
                if (pack_cnt_reg < size_use)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = pack_cnt_reg[ROW_W-1:0];
                    pack_cnt_next = pack_cnt_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_col_next = pack_cnt_reg[ROW_W-1:0];
                end
                if (pend_reg)
                    place_next[pend_col_reg * ROW_W +: ROW_W] = rd_data_reg;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register: hold until taken, load when the request finishes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= RESET_SIZE;
            depth_reg     <= '0;
            row_taken_reg <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            exhausted_reg <= 1'b1;
            try_row_reg   <= '0;
            pack_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            depth_reg     <= depth_next;
            row_taken_reg <= row_taken_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            exhausted_reg <= exhausted_next;
            try_row_reg   <= try_row_next;
            pack_cnt_reg  <= pack_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_col_reg <= pend_col_next;
        found_reg    <= found_next;
        place_reg    <= place_next;
        if (out_load)
        begin
            out_found_reg <= found_reg;
            out_place_reg <= place_reg;
        end
    end

    // Queen row memory: one write and one registered read per cycle.
    // A pop never reads in the cycle of a write, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            queen_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= queen_mem[mem_raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 1 - PLACE_W)'(0), out_place_reg, out_found_reg};

endmodule

// ===== hw/rtl/nqb_row_pick.sv =====
// Free-row finder: lowest safe row at or above a start row in one column.
// Depends on nqb_pkg for widths and the pick result struct.
`timescale 1ns / 1ps

module nqb_row_pick
    import nqb_pkg::*;
(
    input  logic [MAX_QUEENS-1:0] row_taken,
    input  logic [DIAG_W-1:0]     rise_taken,
    input  logic [DIAG_W-1:0]     fall_taken,
    input  logic [ROW_W-1:0]      col,
    input  logic [CNT_W-1:0]      start_row,
    input  logic [CNT_W-1:0]      size,
    output nqb_pick_t             pick
);

    logic [DIAG_W-1:0]     rise_sh;
    logic [DIAG_W-1:0]     fall_sh;
    logic [MAX_QUEENS-1:0] cand;

    // Align both diagonal masks so that bit i belongs to row i of this column
    assign rise_sh = rise_taken >> col;
    assign fall_sh = fall_taken >> (ROW_W'(MAX_QUEENS - 1) - col);

    // Mark rows that are safe, not below the start row and on the board
    always_comb
    begin
        for (int i = 0; i < MAX_QUEENS; i++)
        begin
            cand[i] = !row_taken[i] && !rise_sh[i] && !fall_sh[i] &&
                      (CNT_W'(i) >= start_row) && (CNT_W'(i) < size);
        end
    end

    // Take the lowest candidate row
    always_comb
    begin
        pick.hit = |cand;
        pick.row = '0;
        for (int i = MAX_QUEENS - 1; i >= 0; i--)
        begin
            if (cand[i])
                pick.row = ROW_W'(i);
        end
    end

endmodule

// ===== hw/rtl/nqb_checker.sv =====
// Port-level checker for the N-queens solver, bound to the top level.
// Depends on nqb_pkg for port widths.
`timescale 1ns / 1ps

module nqb_checker
    import nqb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,   // [0] found, [64:1] placement
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A not-found result carries an empty placement
    a_empty_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("not-found result with nonzero placement");

    // Take one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a search runs");

    // Drop ready only for a taken request or a pending register write
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready) || cfg_valid)
        else $error("request ready dropped without cause");

    // Never take a register write and a request together
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(s_tvalid && s_tready))
        else $error("register write and request in one cycle");

endmodule

bind n_queens_backtrack_solver nqb_checker u_nqb_checker (.*);
